@@ rtl/core/mpi_pkg.sv @@
`default_nettype none

package mpi_pkg;

  // Command codes carried by an input beat
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_BASE  = 2'd1,
    CMD_ODOM  = 2'd2,
    CMD_START = 2'd3
  } cmd_e;

  // Reported wait outcome
  typedef enum logic [1:0] {
    OUT_IDLE    = 2'd0,
    OUT_WAIT    = 2'd1,
    OUT_GRANT   = 2'd2,
    OUT_TIMEOUT = 2'd3
  } outcome_e;

  // Configuration register indexes
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgAddrW-1:0] CFG_FRESH_LIMIT  = 4'd0;
  localparam logic [CfgAddrW-1:0] CFG_DWELL_TARGET = 4'd1;
  localparam logic [CfgAddrW-1:0] CFG_MIN_START    = 4'd2;
  localparam logic [CfgAddrW-1:0] CFG_DEADLINE     = 4'd3;
  localparam logic [CfgAddrW-1:0] CFG_SPEED_LIMIT  = 4'd4;
  localparam logic [CfgAddrW-1:0] CFG_READY_STATE  = 4'd5;
  localparam logic [CfgAddrW-1:0] CFG_READY_REASON = 4'd6;
  localparam logic [CfgAddrW-1:0] CFG_POLL_PERIOD  = 4'd7;

  localparam logic [15:0] AGE_MAX = 16'hFFFF;

  typedef struct packed {
    logic [15:0] fresh_limit;
    logic [15:0] dwell_target;
    logic [15:0] min_since_start;
    logic [15:0] deadline_ticks;
    logic [14:0] speed_limit;
    logic [7:0]  ready_state_code;
    logic [7:0]  ready_reason_code;
    logic [7:0]  poll_period;
  } cfg_t;

  // Flags derived from one message beat
  typedef struct packed {
    logic base_ok;
    logic stationary;
  } msg_flags_t;

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    sat_inc16 = (v == AGE_MAX) ? AGE_MAX : v + 16'd1;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/mpi_msg_eval.sv @@
`default_nettype none

module mpi_msg_eval (
  input  mpi_pkg::cfg_t        cfg_i,
  input  logic                 status_valid_i,
  input  logic [31:0]          source_boot_i,
  input  logic [31:0]          status_sequence_i,
  input  logic [7:0]           base_state_i,
  input  logic [7:0]           base_reason_i,
  input  logic signed [15:0]   vel_x_i,
  input  logic signed [15:0]   vel_y_i,
  input  logic signed [15:0]   yaw_rate_i,
  output mpi_pkg::msg_flags_t  flags_o
);
  import mpi_pkg::*;

  // 17-bit magnitude so that the most negative value stays exact
  function automatic logic [16:0] mag16(input logic signed [15:0] v);
    logic [16:0] ext;
    ext = {v[15], v};
    mag16 = v[15] ? (17'd0 - ext) : ext;
  endfunction

  logic [16:0] lim;
  assign lim = {2'b00, cfg_i.speed_limit};

  assign flags_o.base_ok = status_valid_i
                        && (source_boot_i != 32'd0)
                        && (status_sequence_i != 32'd0)
                        && (base_state_i == cfg_i.ready_state_code)
                        && (base_reason_i == cfg_i.ready_reason_code);

  assign flags_o.stationary = (mag16(vel_x_i) <= lim)
                           && (mag16(vel_y_i) <= lim)
                           && (mag16(yaw_rate_i) <= lim);

endmodule

`default_nettype wire

@@ rtl/core/motion_permit_interlock.sv @@
`default_nettype none

// Channel   Dir  Handshake                  Payload
// in        in   in_valid_i / in_ready_o    cmd, status_valid, source_boot,
//                                           status_sequence, base_state,
//                                           base_reason, vel_x, vel_y, yaw_rate
// out       out  out_valid_o / out_ready_i  outcome, evidence_ok
// cfg       in   cfg_we_i                   cfg_addr_i, cfg_wdata_i
//
// One result beat per input beat. A beat is taken every cycle while in_ready_o
// is high: all state updates in the accept cycle, the result lands in the
// output register. in_ready_o drops only while a result is held and not taken.
// Reset restores the configuration defaults and clears all wait state.

module motion_permit_interlock (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [mpi_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [mpi_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // input beats
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    cmd_i,
  input  logic                          status_valid_i,
  input  logic [31:0]                   source_boot_i,
  input  logic [31:0]                   status_sequence_i,
  input  logic [7:0]                    base_state_i,
  input  logic [7:0]                    base_reason_i,
  input  logic signed [15:0]            vel_x_i,
  input  logic signed [15:0]            vel_y_i,
  input  logic signed [15:0]            yaw_rate_i,
  // result beats
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    outcome_o,
  output logic                          evidence_ok_o
);
  import mpi_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fresh_limit       <= 16'd200;
      cfg_q.dwell_target      <= 16'd500;
      cfg_q.min_since_start   <= 16'd400;
      cfg_q.deadline_ticks    <= 16'd8000;
      cfg_q.speed_limit       <= 15'd10;
      cfg_q.ready_state_code  <= 8'd0;
      cfg_q.ready_reason_code <= 8'd0;
      cfg_q.poll_period       <= 8'd20;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_FRESH_LIMIT:  cfg_q.fresh_limit       <= cfg_wdata_i;
        CFG_DWELL_TARGET: cfg_q.dwell_target      <= cfg_wdata_i;
        CFG_MIN_START:    cfg_q.min_since_start   <= cfg_wdata_i;
        CFG_DEADLINE:     cfg_q.deadline_ticks    <= cfg_wdata_i;
        CFG_SPEED_LIMIT:  cfg_q.speed_limit       <= cfg_wdata_i[14:0];
        CFG_READY_STATE:  cfg_q.ready_state_code  <= cfg_wdata_i[7:0];
        CFG_READY_REASON: cfg_q.ready_reason_code <= cfg_wdata_i[7:0];
        CFG_POLL_PERIOD:  cfg_q.poll_period       <= cfg_wdata_i[7:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Message flags
  // ---------------------------------------------------------------------
  msg_flags_t flags;

  mpi_msg_eval u_msg_eval (
    .cfg_i             (cfg_q),
    .status_valid_i    (status_valid_i),
    .source_boot_i     (source_boot_i),
    .status_sequence_i (status_sequence_i),
    .base_state_i      (base_state_i),
    .base_reason_i     (base_reason_i),
    .vel_x_i           (vel_x_i),
    .vel_y_i           (vel_y_i),
    .yaw_rate_i        (yaw_rate_i),
    .flags_o           (flags)
  );

  // ---------------------------------------------------------------------
  // Wait state
  // ---------------------------------------------------------------------
  logic        running_q, running_d;
  logic        base_seen_q, base_seen_d;
  logic        odom_seen_q, odom_seen_d;
  logic        base_ok_q, base_ok_d;
  logic        stationary_q, stationary_d;
  logic [15:0] base_age_q, base_age_d;
  logic [15:0] odom_age_q, odom_age_d;
  logic [15:0] since_start_q, since_start_d;
  logic        dwell_active_q, dwell_active_d;
  logic [15:0] dwell_count_q, dwell_count_d;
  logic [7:0]  poll_phase_q, poll_phase_d;
  logic        last_ok_q, last_ok_d;
  outcome_e    outcome_q, outcome_d;

  logic        in_fire;
  logic        ok;
  logic [7:0]  period;
  logic [8:0]  phase_inc;

  assign in_fire   = in_valid_i && in_ready_o;
  assign period    = (cfg_q.poll_period == 8'd0) ? 8'd1 : cfg_q.poll_period;
  assign phase_inc = {1'b0, poll_phase_q} + 9'd1;

  always_comb begin
    running_d      = running_q;
    base_seen_d    = base_seen_q;
    odom_seen_d    = odom_seen_q;
    base_ok_d      = base_ok_q;
    stationary_d   = stationary_q;
    base_age_d     = base_age_q;
    odom_age_d     = odom_age_q;
    since_start_d  = since_start_q;
    dwell_active_d = dwell_active_q;
    dwell_count_d  = dwell_count_q;
    poll_phase_d   = poll_phase_q;
    last_ok_d      = last_ok_q;
    outcome_d      = outcome_q;

    // evidence sees the ages after this tick's increment
    ok = base_seen_q && (sat_inc16(base_age_q) <= cfg_q.fresh_limit) && base_ok_q
      && odom_seen_q && (sat_inc16(odom_age_q) <= cfg_q.fresh_limit) && stationary_q;

    unique case (cmd_e'(cmd_i))
      CMD_TICK: begin
        base_age_d = sat_inc16(base_age_q);
        odom_age_d = sat_inc16(odom_age_q);
        if (running_q) begin
          since_start_d = sat_inc16(since_start_q);
          if (dwell_active_q) begin
            dwell_count_d = sat_inc16(dwell_count_q);
          end
          if (since_start_d >= cfg_q.deadline_ticks) begin
            running_d = 1'b0;
            outcome_d = OUT_TIMEOUT;
          end else begin
            if (poll_phase_q == 8'd0) begin
              if (ok) begin
                if (!dwell_active_q) begin
                  dwell_active_d = 1'b1;
                  dwell_count_d  = 16'd0;
                end
              end else begin
                dwell_active_d = 1'b0;
                dwell_count_d  = 16'd0;
              end
              last_ok_d = ok;
            end
            if ((poll_phase_q == 8'd0) && (since_start_d >= cfg_q.min_since_start)
                && dwell_active_d && (dwell_count_d >= cfg_q.dwell_target)) begin
              running_d = 1'b0;
              outcome_d = OUT_GRANT;
            end else begin
              poll_phase_d = (phase_inc >= {1'b0, period}) ? 8'd0 : phase_inc[7:0];
            end
          end
        end
      end
      CMD_BASE: begin
        base_seen_d = 1'b1;
        base_age_d  = 16'd0;
        base_ok_d   = flags.base_ok;
      end
      CMD_ODOM: begin
        odom_seen_d  = 1'b1;
        odom_age_d   = 16'd0;
        stationary_d = flags.stationary;
      end
      CMD_START: begin
        running_d      = 1'b1;
        outcome_d      = OUT_WAIT;
        since_start_d  = 16'd0;
        poll_phase_d   = 8'd0;
        dwell_active_d = 1'b0;
        dwell_count_d  = 16'd0;
        last_ok_d      = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q      <= 1'b0;
      base_seen_q    <= 1'b0;
      odom_seen_q    <= 1'b0;
      base_ok_q      <= 1'b0;
      stationary_q   <= 1'b0;
      base_age_q     <= 16'd0;
      odom_age_q     <= 16'd0;
      since_start_q  <= 16'd0;
      dwell_active_q <= 1'b0;
      dwell_count_q  <= 16'd0;
      poll_phase_q   <= 8'd0;
      last_ok_q      <= 1'b0;
      outcome_q      <= OUT_IDLE;
    end else if (in_fire) begin
      running_q      <= running_d;
      base_seen_q    <= base_seen_d;
      odom_seen_q    <= odom_seen_d;
      base_ok_q      <= base_ok_d;
      stationary_q   <= stationary_d;
      base_age_q     <= base_age_d;
      odom_age_q     <= odom_age_d;
      since_start_q  <= since_start_d;
      dwell_active_q <= dwell_active_d;
      dwell_count_q  <= dwell_count_d;
      poll_phase_q   <= poll_phase_d;
      last_ok_q      <= last_ok_d;
      outcome_q      <= outcome_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result register: one beat per accepted input beat
  // ---------------------------------------------------------------------
  logic       out_valid_q;
  logic [1:0] out_outcome_q;
  logic       out_ok_q;

  assign in_ready_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_outcome_q <= outcome_d;
      out_ok_q      <= last_ok_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign outcome_o     = out_outcome_q;
  assign evidence_ok_o = out_ok_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // the wait runs exactly while the outcome reads waiting
  a_run_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q == (outcome_q == OUT_WAIT))
    else $error("running flag and outcome disagree");

  // an inactive dwell always holds a cleared count
  a_dwell_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !dwell_active_q |-> (dwell_count_q == 16'd0))
    else $error("dwell count nonzero while dwell inactive");

  // a start beat restarts the wait from zero
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (cmd_i == CMD_START)) |=>
      (running_q && (since_start_q == 16'd0) && (poll_phase_q == 8'd0) && out_valid_q))
    else $error("start beat did not restart the wait");

endmodule

`default_nettype wire

@@ tb/sv/motion_permit_interlock_checker.sv @@
`timescale 1ns / 100ps

module motion_permit_interlock_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mpi_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [mpi_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [1:0]                   cmd_i,
  input  logic                         status_valid_i,
  input  logic [31:0]                  source_boot_i,
  input  logic [31:0]                  status_sequence_i,
  input  logic [7:0]                   base_state_i,
  input  logic [7:0]                   base_reason_i,
  input  logic [15:0]                  vel_x_i,
  input  logic [15:0]                  vel_y_i,
  input  logic [15:0]                  yaw_rate_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [1:0]                   outcome_i,
  input  logic                         evidence_ok_i,
  output int unsigned                  mismatch_count_o,
  output int unsigned                  reports_due_o,
  output int unsigned                  reports_checked_o,
  output int unsigned                  grants_o,
  output int unsigned                  timeouts_o
);
  import mpi_pkg::*;

  typedef struct packed {
    outcome_e outcome;
    logic     evidence_ok;
  } permit_report_t;

  permit_report_t report_q[$];
  permit_report_t want;
  cfg_t           regs;

  logic        armed, base_heard, odom_heard, base_good, platform_still;
  logic        dwell_on, verdict_ok;
  logic [15:0] base_ticks, odom_ticks, wait_ticks, dwell_ticks;
  logic [7:0]  poll_ctr;
  outcome_e    permit_state;
  int unsigned mismatches, checked, grants, timeouts;

  function automatic logic [15:0] sat_bump(input logic [15:0] v);
    return (v == AGE_MAX) ? v : v + 16'd1;
  endfunction

  // |v| of a two's complement value; -32768 gives 32768
  function automatic logic [15:0] magnitude(input logic [15:0] v);
    return v[15] ? (~v + 16'd1) : v;
  endfunction

  task automatic take_tick();
    logic [7:0] period;
    logic       good;
    period = (regs.poll_period == 8'd0) ? 8'd1 : regs.poll_period;
    base_ticks = sat_bump(base_ticks);
    odom_ticks = sat_bump(odom_ticks);
    if (armed) begin
      wait_ticks = sat_bump(wait_ticks);
      if (dwell_on) dwell_ticks = sat_bump(dwell_ticks);
      if (wait_ticks >= regs.deadline_ticks) begin
        armed = 1'b0;
        permit_state = OUT_TIMEOUT;
        timeouts++;
      end else begin
        if (poll_ctr == 8'd0) begin
          good = base_heard && base_ticks <= regs.fresh_limit && base_good &&
                 odom_heard && odom_ticks <= regs.fresh_limit && platform_still;
          if (!good) begin
            dwell_on    = 1'b0;
            dwell_ticks = 16'd0;
          end else if (!dwell_on) begin
            dwell_on    = 1'b1;
            dwell_ticks = 16'd0;
          end
          verdict_ok = good;
          if (wait_ticks >= regs.min_since_start && dwell_on &&
              dwell_ticks >= regs.dwell_target) begin
            armed = 1'b0;
            permit_state = OUT_GRANT;
            grants++;
          end
        end
        // a grant leaves the poll counter where it was
        if (armed) begin
          poll_ctr = ({1'b0, poll_ctr} + 9'd1 >= {1'b0, period}) ? 8'd0 : poll_ctr + 8'd1;
        end
      end
    end
  endtask

  task automatic take_beat();
    case (cmd_e'(cmd_i))
      CMD_TICK: take_tick();
      CMD_BASE: begin
        base_heard = 1'b1;
        base_ticks = 16'd0;
        base_good  = status_valid_i && source_boot_i != 32'd0 &&
                     status_sequence_i != 32'd0 &&
                     base_state_i == regs.ready_state_code &&
                     base_reason_i == regs.ready_reason_code;
      end
      CMD_ODOM: begin
        odom_heard     = 1'b1;
        odom_ticks     = 16'd0;
        platform_still = magnitude(vel_x_i) <= {1'b0, regs.speed_limit} &&
                         magnitude(vel_y_i) <= {1'b0, regs.speed_limit} &&
                         magnitude(yaw_rate_i) <= {1'b0, regs.speed_limit};
      end
      default: begin
        armed        = 1'b1;
        permit_state = OUT_WAIT;
        wait_ticks   = 16'd0;
        poll_ctr     = 8'd0;
        dwell_on     = 1'b0;
        dwell_ticks  = 16'd0;
        verdict_ok   = 1'b0;
      end
    endcase
    report_q.insert(report_q.size(), '{outcome: permit_state, evidence_ok: verdict_ok});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs.fresh_limit       = 16'd200;
      regs.dwell_target      = 16'd500;
      regs.min_since_start   = 16'd400;
      regs.deadline_ticks    = 16'd8000;
      regs.speed_limit       = 15'd10;
      regs.ready_state_code  = 8'd0;
      regs.ready_reason_code = 8'd0;
      regs.poll_period       = 8'd20;
      {armed, base_heard, odom_heard, base_good, platform_still} = '0;
      {dwell_on, verdict_ok} = '0;
      {base_ticks, odom_ticks, wait_ticks, dwell_ticks} = '0;
      poll_ctr     = 8'd0;
      permit_state = OUT_IDLE;
      report_q.delete();
      mismatches = 0;
      checked    = 0;
      grants     = 0;
      timeouts   = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (report_q.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with nothing expected, actual outcome %0d evidence_ok %0b",
                   $time, outcome_i, evidence_ok_i);
        end else begin
          want = report_q.pop_front();
          checked++;
          if (outcome_i !== want.outcome) begin
            mismatches++;
            $display("%0t: outcome expected %0d actual %0d", $time, want.outcome, outcome_i);
          end
          if (evidence_ok_i !== want.evidence_ok) begin
            mismatches++;
            $display("%0t: evidence_ok expected %0b actual %0b",
                     $time, want.evidence_ok, evidence_ok_i);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_FRESH_LIMIT:  regs.fresh_limit       = cfg_wdata_i;
          CFG_DWELL_TARGET: regs.dwell_target      = cfg_wdata_i;
          CFG_MIN_START:    regs.min_since_start   = cfg_wdata_i;
          CFG_DEADLINE:     regs.deadline_ticks    = cfg_wdata_i;
          CFG_SPEED_LIMIT:  regs.speed_limit       = cfg_wdata_i[14:0];
          CFG_READY_STATE:  regs.ready_state_code  = cfg_wdata_i[7:0];
          CFG_READY_REASON: regs.ready_reason_code = cfg_wdata_i[7:0];
          CFG_POLL_PERIOD:  regs.poll_period       = cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) take_beat();
    end
    mismatch_count_o  <= mismatches;
    reports_due_o     <= report_q.size();
    reports_checked_o <= checked;
    grants_o          <= grants;
    timeouts_o        <= timeouts;
  end

endmodule

@@ tb/sv/motion_permit_interlock_test.sv @@
`timescale 1ns / 100ps

// Stimulus and verdict for the motion-permit interlock. All prediction and
// comparison lives in the checker instance; this module only makes beats,
// register setups and back-pressure.
module motion_permit_interlock_test;
  import mpi_pkg::*;

  localparam int unsigned QuietLimit   = 2000; // cycles with no beat or register write
  localparam int unsigned HoldCycles   = 64;   // one long receiver hold-off
  localparam int unsigned RandomSetups = 6;
  localparam int unsigned BeatsPerSetup = 105;

  // Raw register images; upper bits beyond a register's width are written
  // on purpose so the block's masking gets exercised.
  typedef struct {
    logic [15:0] fresh;
    logic [15:0] dwell;
    logic [15:0] min_start;
    logic [15:0] deadline;
    logic [15:0] speed;
    logic [15:0] state_code;
    logic [15:0] reason_code;
    logic [15:0] poll;
  } setup_t;

  typedef struct {
    cmd_e        cmd;
    logic        status_valid;
    logic [31:0] boot;
    logic [31:0] seq;
    logic [7:0]  state;
    logic [7:0]  reason;
    logic [15:0] vel_x;
    logic [15:0] vel_y;
    logic [15:0] yaw;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                cfg_we;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [CfgDataW-1:0] cfg_wdata;

  logic        in_valid;
  logic        in_ready;
  cmd_e        cmd;
  logic        status_valid;
  logic [31:0] source_boot;
  logic [31:0] status_sequence;
  logic [7:0]  base_state;
  logic [7:0]  base_reason;
  logic [15:0] vel_x;
  logic [15:0] vel_y;
  logic [15:0] yaw_rate;

  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] outcome;
  logic       evidence_ok;

  int unsigned mismatches, reports_due, reports_checked, grants, timeouts;

  // back-pressure knobs
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;

  int unsigned quiet_cycles = 0;
  int unsigned beats_sent = 0;
  int unsigned setups_loaded = 0;
  setup_t      live; // what the block currently holds, used to aim messages

  always #5 clk = ~clk;

  motion_permit_interlock u_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_addr_i        (cfg_addr),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .cmd_i             (cmd),
    .status_valid_i    (status_valid),
    .source_boot_i     (source_boot),
    .status_sequence_i (status_sequence),
    .base_state_i      (base_state),
    .base_reason_i     (base_reason),
    .vel_x_i           (vel_x),
    .vel_y_i           (vel_y),
    .yaw_rate_i        (yaw_rate),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .outcome_o         (outcome),
    .evidence_ok_o     (evidence_ok)
  );

  motion_permit_interlock_checker u_check (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_addr_i        (cfg_addr),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .cmd_i             (cmd),
    .status_valid_i    (status_valid),
    .source_boot_i     (source_boot),
    .status_sequence_i (status_sequence),
    .base_state_i      (base_state),
    .base_reason_i     (base_reason),
    .vel_x_i           (vel_x),
    .vel_y_i           (vel_y),
    .yaw_rate_i        (yaw_rate),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .outcome_i         (outcome),
    .evidence_ok_i     (evidence_ok),
    .mismatch_count_o  (mismatches),
    .reports_due_o     (reports_due),
    .reports_checked_o (reports_checked),
    .grants_o          (grants),
    .timeouts_o        (timeouts)
  );

  // Result side. Random stalls at recv_idle_pct, plus one long hold-off on
  // request: the block then fills and has to drop in_ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HoldCycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: any beat or register write counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Watchdog: %0d cycles without a beat", quiet_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic setup_t make_setup(input logic [15:0] fresh, dwell, min_start, deadline,
                                        speed, state_code, reason_code, poll);
    setup_t s;
    s.fresh       = fresh;
    s.dwell       = dwell;
    s.min_start   = min_start;
    s.deadline    = deadline;
    s.speed       = speed;
    s.state_code  = state_code;
    s.reason_code = reason_code;
    s.poll        = poll;
    return s;
  endfunction

  // Mostly short timing so grants and timeouts happen within a phase.
  // Poll period 0 is legal on the port and behaves as 1.
  function automatic setup_t random_setup();
    return make_setup(16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)),
                      16'($urandom_range(0, 12)), 16'($urandom_range(1, 48)),
                      {1'($urandom), 15'($urandom_range(0, 40))},
                      {8'($urandom), 8'($urandom_range(0, 3))},
                      {8'($urandom), 8'($urandom_range(0, 3))},
                      {8'($urandom), 8'($urandom_range(0, 4))});
  endfunction

  function automatic beat_t scramble(input cmd_e c);
    beat_t b;
    b.cmd          = c;
    b.status_valid = 1'($urandom);
    b.boot         = $urandom;
    b.seq          = $urandom;
    b.state        = 8'($urandom);
    b.reason       = 8'($urandom);
    b.vel_x        = 16'($urandom);
    b.vel_y        = 16'($urandom);
    b.yaw          = 16'($urandom);
    return b;
  endfunction

  function automatic beat_t status_beat(input logic v, input logic [31:0] boot, seq,
                                        input logic [7:0] st, rs);
    beat_t b;
    b = scramble(CMD_BASE);
    b.status_valid = v;
    b.boot   = boot;
    b.seq    = seq;
    b.state  = st;
    b.reason = rs;
    return b;
  endfunction

  function automatic beat_t odom_beat(input logic [15:0] x, y, w);
    beat_t b;
    b = scramble(CMD_ODOM);
    b.vel_x = x;
    b.vel_y = y;
    b.yaw   = w;
    return b;
  endfunction

  function automatic logic [31:0] nonzero32();
    return $urandom_range(1, 32'hFFFF_FFFF);
  endfunction

  // signed value in [-lim, lim]
  function automatic logic [15:0] near_zero(input logic [14:0] lim);
    return 16'(int'($urandom_range(0, 2 * int'(lim))) - int'(lim));
  endfunction

  // Well-formed traffic dominates: ticks, mostly healthy status and
  // stationary odometry aimed at the live codes, occasional starts. A slice
  // is broken messages and plain noise.
  function automatic beat_t random_beat();
    beat_t       b;
    int unsigned pick;
    logic [14:0] lim;
    pick = $urandom_range(0, 99);
    lim  = live.speed[14:0];
    if (pick < 55) begin
      b = scramble(CMD_TICK);
    end else if (pick < 72) begin
      b = status_beat(1'b1, nonzero32(), nonzero32(), live.state_code[7:0],
                      live.reason_code[7:0]);
      if ($urandom_range(0, 99) < 25) begin
        case ($urandom_range(0, 5))
          0: b.status_valid = 1'b0;
          1: b.boot = 32'd0;
          2: b.seq = 32'd0;
          3: b.state = b.state + 8'($urandom_range(1, 255));
          4: b.reason = b.reason + 8'($urandom_range(1, 255));
          default: b = scramble(CMD_BASE);
        endcase
      end
    end else if (pick < 89) begin
      if ($urandom_range(0, 99) < 75) begin
        b = odom_beat(near_zero(lim), near_zero(lim), near_zero(lim));
      end else begin
        b = scramble(CMD_ODOM);
        if ($urandom_range(0, 3) == 0) b.yaw = 16'h8000;
      end
    end else if (pick < 93) begin
      b = scramble(CMD_START);
    end else begin
      b = scramble(cmd_e'($urandom_range(0, 3)));
    end
    return b;
  endfunction

  // All put_reg/offer/quiesce calls start and end on a rising edge.
  task automatic put_reg(input logic [CfgAddrW-1:0] addr, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Writes every register plus one unmapped index, back to back.
  task automatic load_setup(input setup_t s);
    put_reg(CFG_FRESH_LIMIT, s.fresh);
    put_reg(CFG_DWELL_TARGET, s.dwell);
    put_reg(CFG_MIN_START, s.min_start);
    put_reg(CFG_DEADLINE, s.deadline);
    put_reg(CFG_SPEED_LIMIT, s.speed);
    put_reg(CFG_READY_STATE, s.state_code);
    put_reg(CFG_READY_REASON, s.reason_code);
    put_reg(CFG_POLL_PERIOD, s.poll);
    put_reg(CFG_POLL_PERIOD + 4'($urandom_range(1, 8)), 16'($urandom));
    cfg_we <= 1'b0;
    live = s;
    setups_loaded++;
  endtask

  task automatic offer(input beat_t b);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid        <= 1'b1;
    cmd             <= b.cmd;
    status_valid    <= b.status_valid;
    source_boot     <= b.boot;
    status_sequence <= b.seq;
    base_state      <= b.state;
    base_reason     <= b.reason;
    vel_x           <= b.vel_x;
    vel_y           <= b.vel_y;
    yaw_rate        <= b.yaw;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  // Drain every expected result, then let the block settle so that it
  // is idle before registers change.
  task automatic quiesce();
    in_valid <= 1'b0;
    do @(negedge clk); while (reports_due != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic tick_run(input int unsigned n);
    repeat (n) offer(scramble(CMD_TICK));
  endtask

  initial begin
    setup_t s;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_addr        = '0;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    cmd             = CMD_TICK;
    status_valid    = 1'b0;
    source_boot     = '0;
    status_sequence = '0;
    base_state      = '0;
    base_reason     = '0;
    vel_x           = '0;
    vel_y           = '0;
    yaw_rate        = '0;
    send_idle_pct   = 24;
    recv_idle_pct   = 69;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: fast timing, poll every other tick, speed limit 10.
    load_setup(make_setup(16'd3, 16'd2, 16'd3, 16'd4, 16'd10, 16'd5, 16'd7, 16'd2));
    offer(scramble(CMD_TICK));                                    // idle tick
    offer(odom_beat(16'hFFF6, 16'd10, 16'd0));                    // exactly at limit
    offer(status_beat(1'b1, 32'hFFFF_FFFF, 32'd1, 8'd5, 8'd7));   // ready
    offer(scramble(CMD_START));
    tick_run(3);                                                  // grant on third tick
    offer(scramble(CMD_TICK));                                    // finished, holds
    offer(status_beat(1'b0, 32'd1, 32'd1, 8'd5, 8'd7));           // flag not valid
    offer(scramble(CMD_START));                                   // restart after grant
    offer(scramble(CMD_TICK));                                    // poll fails
    offer(status_beat(1'b1, 32'd0, 32'hFFFF_FFFF, 8'd5, 8'd7));   // zero boot id
    offer(odom_beat(16'h8000, 16'h7FFF, 16'hFFF5));               // full-scale motion
    offer(scramble(CMD_START));                                   // restart while running
    tick_run(4);                                                  // runs into deadline
    quiesce();

    // Zero deadline and zero poll period: first tick after start times out.
    load_setup(make_setup(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
    offer(scramble(CMD_START));
    offer(scramble(CMD_TICK));
    quiesce();

    // Zero dwell target and zero minimum: first good poll grants.
    load_setup(make_setup(16'd2, 16'd0, 16'd0, 16'd100, 16'h8000, 16'd0, 16'd0, 16'd0));
    offer(status_beat(1'b1, 32'd1, 32'd1, 8'd0, 8'd0));
    offer(odom_beat(16'd0, 16'd0, 16'd0));
    offer(scramble(CMD_START));
    offer(scramble(CMD_TICK));
    quiesce();

    // Random phases: full-scale and all-zero setups among random ones.
    for (int p = 0; p < RandomSetups; p++) begin
      case (p)
        1:       s = make_setup('1, '1, '1, '1, '1, '1, '1, '1);
        4:       s = make_setup('0, '0, '0, '0, '0, '0, '0, '0);
        default: s = random_setup();
      endcase
      if (p == 2) begin
        send_idle_pct = 69;
        recv_idle_pct <= 24;
      end
      if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      load_setup(s);
      for (int n = 0; n < BeatsPerSetup; n++) begin
        if (p == 4 && n == 20) hold_req <= 1'b1;
        offer(random_beat());
      end
      quiesce();
    end

    $display("Coverage: %0d input beats over %0d register setups (zero, full-scale, random)",
             beats_sent, setups_loaded);
    $display("Coverage: %0d results compared, %0d grants, %0d timeouts, %0d-cycle hold-off",
             reports_checked, grants, timeouts, HoldCycles);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
